/* hw/rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg - shared constants and tables for the degree trig table unit
// Angle periods, function select codes, Q14 sine and tangent quarter tables,
// and the per-byte residue tables used by the modulo-360 reduction.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int FULL_TURN          = 360;
    localparam int HALF_TURN          = 180;
    localparam int QUARTER_TURN       = 90;
    localparam int THREE_QUARTER_TURN = 270;

    // 2^32 mod 360 is 256, so a set sign bit adds 360 - 256 to the residue sum
    localparam int SIGN_RES = 104;

    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;
    localparam int RES_W   = 9;   // residue 0..359
    localparam int SUM_W   = 11;  // four residues plus sign term, up to 1540
    localparam int IDX_W   = 7;   // quarter table index 0..90

    localparam logic [FUNC_W-1:0] FUNC_SIN = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COS = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TAN = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_COT = 2'd3;

    typedef logic [RES_W-1:0] t_res_tab [256];

    // residue of (byte * weight) mod 360, worked out at elaboration
    function automatic t_res_tab build_res_tab(input int unsigned weight);
        t_res_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = RES_W'((int'(i) * int'(weight)) % FULL_TURN);
        end
        return tab;
    endfunction

    // byte weights: 2^0, 2^8, 2^16, 2^24 modulo 360
    localparam t_res_tab RES_B0 = build_res_tab(1);
    localparam t_res_tab RES_B1 = build_res_tab(256);
    localparam t_res_tab RES_B2 = build_res_tab(16);
    localparam t_res_tab RES_B3 = build_res_tab(136);

    localparam logic [14:0] SINE_Q14 [91] = '{
        15'd0,     15'd285,   15'd571,   15'd857,   15'd1142,  15'd1427,
        15'd1712,  15'd1996,  15'd2280,  15'd2563,  15'd2845,
        15'd3126,  15'd3406,  15'd3685,  15'd3963,  15'd4240,  15'd4516,
        15'd4790,  15'd5062,  15'd5334,  15'd5603,
        15'd5871,  15'd6137,  15'd6401,  15'd6663,  15'd6924,  15'd7182,
        15'd7438,  15'd7691,  15'd7943,  15'd8191,
        15'd8438,  15'd8682,  15'd8923,  15'd9161,  15'd9397,  15'd9630,
        15'd9860,  15'd10086, 15'd10310, 15'd10531,
        15'd10748, 15'd10963, 15'd11173, 15'd11381, 15'd11585, 15'd11785,
        15'd11982, 15'd12175, 15'd12365, 15'd12550,
        15'd12732, 15'd12910, 15'd13084, 15'd13254, 15'd13420, 15'd13582,
        15'd13740, 15'd13894, 15'd14043, 15'd14188,
        15'd14329, 15'd14466, 15'd14598, 15'd14725, 15'd14848, 15'd14967,
        15'd15081, 15'd15190, 15'd15295, 15'd15395,
        15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15825, 15'd15897,
        15'd15964, 15'd16025, 15'd16082, 15'd16135,
        15'd16182, 15'd16224, 15'd16261, 15'd16294, 15'd16321, 15'd16344,
        15'd16361, 15'd16374, 15'd16381, 15'd16384
    };

    localparam logic [30:0] TAN_Q14 [91] = '{
        31'd0,      31'd285,    31'd572,    31'd858,    31'd1145,   31'd1433,
        31'd1722,   31'd2011,   31'd2302,   31'd2594,   31'd2888,
        31'd3184,   31'd3482,   31'd3782,   31'd4084,   31'd4390,   31'd4698,
        31'd5009,   31'd5323,   31'd5641,   31'd5963,
        31'd6289,   31'd6619,   31'd6954,   31'd7294,   31'd7639,   31'd7991,
        31'd8348,   31'd8711,   31'd9081,   31'd9459,
        31'd9844,   31'd10237,  31'd10639,  31'd11051,  31'd11472,  31'd11903,
        31'd12346,  31'd12800,  31'd13267,  31'd13747,
        31'd14242,  31'd14752,  31'd15278,  31'd15821,  31'd16384,  31'd16966,
        31'd17569,  31'd18196,  31'd18847,  31'd19525,
        31'd20232,  31'd20970,  31'd21742,  31'd22550,  31'd23398,  31'd24290,
        31'd25229,  31'd26219,  31'd27267,  31'd28377,
        31'd29557,  31'd30813,  31'd32155,  31'd33592,  31'd35135,  31'd36799,
        31'd38598,  31'd40551,  31'd42681,  31'd45014,
        31'd47582,  31'd50424,  31'd53589,  31'd57137,  31'd61145,  31'd65712,
        31'd70966,  31'd77080,  31'd84288,  31'd92918,
        31'd103444, 31'd116578, 31'd133436, 31'd155883, 31'd187269, 31'd234302,
        31'd312625, 31'd469176, 31'd938638,
        31'd2147483647
    };

endpackage

/* hw/rtl/degree_trig_table_unit.sv */
// ----------------------------------------------------------------------------
// degree_trig_table_unit - Q14 sine, cosine, tangent, cotangent of whole degrees
// Reduces a signed angle modulo 360 (or 180), folds it onto a quarter-wave
// table and returns the table value, negated where the quadrant calls for it.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                | tuser      | notes
//  ---------+-----+----------------------+------------+------------------------
//  s_axis   | in  | [31:0] angle, signed | [1:0] func | 0 sin,1 cos,2 tan,3 cot
//  m_axis   | out | [31:0] value, signed | -          | one result per request
//
//  An input register, then the reduction and table lookup, then the result
//  register. One request per cycle sustained while the output is not stalled;
//  the byte residue tables and adder in dtt_reduce set the path between them.
//  Both stages hold while o_m_axis_tvalid is high and i_m_axis_tready is low;
//  the input side still takes a request while the input stage is empty.
//  Synchronous active-low reset empties both stages; payload is not reset.
//
module degree_trig_table_unit
    import dtt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [ANGLE_W-1:0]   i_s_axis_tdata,   // [31:0] angle
    input  logic [FUNC_W-1:0]    i_s_axis_tuser,   // [1:0] func

    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [VALUE_W-1:0]   o_m_axis_tdata    // [31:0] value
);

    // pipeline control
    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 adv_in;
    logic                 adv_out;

    // stage payload
    logic [FUNC_W-1:0]    r_in_func;
    logic [ANGLE_W-1:0]   r_in_angle;
    logic [VALUE_W-1:0]   r_out_value;
    logic [VALUE_W-1:0]   n_out_value;

    // reduction and folding
    logic [RES_W-1:0]     r360;
    logic [RES_W:0]       cos_sum;
    logic [RES_W-1:0]     cos_ang;
    logic [RES_W-1:0]     sin_ang;
    logic [7:0]           r180;
    logic [7:0]           cot_ang;
    logic [7:0]           tan_ang;
    logic [IDX_W-1:0]     sin_idx;
    logic                 sin_neg;
    logic [IDX_W-1:0]     tan_idx;
    logic                 tan_neg;
    logic [VALUE_W-1:0]   sin_mag;
    logic [VALUE_W-1:0]   tan_mag;

    // the input stage moves on whenever it is empty or the result stage can take its item
    assign adv_out         = !r_out_valid || i_m_axis_tready;
    assign adv_in          = !r_in_valid || adv_out;
    assign o_s_axis_tready = adv_in;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (adv_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_s_axis_tvalid) begin
            r_in_func  <= i_s_axis_tuser;
            r_in_angle <= i_s_axis_tdata;
        end
        if (adv_out && r_in_valid) begin
            r_out_value <= n_out_value;
        end
    end

    dtt_reduce u_reduce (
        .i_angle (r_in_angle),
        .o_res   (r360)
    );

    always_comb begin
        // cosine: residue of angle + 90 taken from the residue, so no wrap
        cos_sum = {1'b0, r360} + (RES_W + 1)'(QUARTER_TURN);
        if (cos_sum >= (RES_W + 1)'(FULL_TURN)) begin
            cos_ang = RES_W'(cos_sum - (RES_W + 1)'(FULL_TURN));
        end else begin
            cos_ang = RES_W'(cos_sum);
        end
        sin_ang = (r_in_func == FUNC_COS) ? cos_ang : r360;

        // fold the full turn onto the quarter table
        if (sin_ang <= RES_W'(QUARTER_TURN)) begin
            sin_idx = IDX_W'(sin_ang);
            sin_neg = 1'b0;
        end else if (sin_ang <= RES_W'(HALF_TURN)) begin
            sin_idx = IDX_W'(RES_W'(HALF_TURN) - sin_ang);
            sin_neg = 1'b0;
        end else if (sin_ang <= RES_W'(THREE_QUARTER_TURN)) begin
            sin_idx = IDX_W'(sin_ang - RES_W'(HALF_TURN));
            sin_neg = 1'b1;
        end else begin
            sin_idx = IDX_W'(RES_W'(FULL_TURN) - sin_ang);
            sin_neg = 1'b1;
        end

        // tangent period is half a turn
        if (r360 >= RES_W'(HALF_TURN)) begin
            r180 = 8'(r360 - RES_W'(HALF_TURN));
        end else begin
            r180 = 8'(r360);
        end

        // cotangent: (90 - angle) mod 180
        if (r180 <= 8'(QUARTER_TURN)) begin
            cot_ang = 8'(QUARTER_TURN) - r180;
        end else begin
            cot_ang = 8'(RES_W'(THREE_QUARTER_TURN) - {1'b0, r180});
        end
        tan_ang = (r_in_func == FUNC_COT) ? cot_ang : r180;

        // second quadrant mirrors with a sign flip; the pole stays positive
        if (tan_ang > 8'(QUARTER_TURN)) begin
            tan_idx = IDX_W'(8'(HALF_TURN) - tan_ang);
            tan_neg = 1'b1;
        end else begin
            tan_idx = IDX_W'(tan_ang);
            tan_neg = 1'b0;
        end

        sin_mag = VALUE_W'(SINE_Q14[sin_idx]);
        tan_mag = VALUE_W'(TAN_Q14[tan_idx]);

        case (r_in_func)
            FUNC_SIN, FUNC_COS: begin
                n_out_value = sin_neg ? (VALUE_W'(0) - sin_mag) : sin_mag;
            end
            FUNC_TAN, FUNC_COT: begin
                n_out_value = tan_neg ? (VALUE_W'(0) - tan_mag) : tan_mag;
            end
            default: begin
                n_out_value = sin_mag;
            end
        endcase
    end

endmodule

/* hw/rtl/dtt_reduce.sv */
// ----------------------------------------------------------------------------
// dtt_reduce - signed 32-bit angle modulo 360
// Splits the angle into bytes, sums their residues from constant tables, adds
// the sign term and folds the small sum back into 0..359.
// ----------------------------------------------------------------------------
module dtt_reduce
    import dtt_pkg::*;
(
    input  logic [ANGLE_W-1:0] i_angle,
    output logic [RES_W-1:0]   o_res
);

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] sub;

    always_comb begin
        sum = SUM_W'(RES_B0[i_angle[7:0]])
            + SUM_W'(RES_B1[i_angle[15:8]])
            + SUM_W'(RES_B2[i_angle[23:16]])
            + SUM_W'(RES_B3[i_angle[31:24]])
            + (i_angle[ANGLE_W-1] ? SUM_W'(SIGN_RES) : '0);

        // sum is below 5 * 360: one parallel compare set, then one subtract
        if (sum >= SUM_W'(4 * FULL_TURN)) begin
            sub = SUM_W'(4 * FULL_TURN);
        end else if (sum >= SUM_W'(3 * FULL_TURN)) begin
            sub = SUM_W'(3 * FULL_TURN);
        end else if (sum >= SUM_W'(2 * FULL_TURN)) begin
            sub = SUM_W'(2 * FULL_TURN);
        end else if (sum >= SUM_W'(FULL_TURN)) begin
            sub = SUM_W'(FULL_TURN);
        end else begin
            sub = '0;
        end

        o_res = RES_W'(sum - sub);
    end

endmodule
